[rtl/gha_pkg.sv]
// Shared constants, codes and types of the generational handle allocator.
`timescale 1ns / 1ps
package gha_pkg;

    localparam int SLOTS    = 256;
    localparam int IDX_W    = 8;
    localparam int CNT_W    = 9;
    localparam int GEN_W    = 32;
    localparam int UUID_W   = 64;
    localparam int IN_W     = 176;
    localparam int OUT_W    = 184;

    typedef enum logic [2:0] {
        ACT_CREATE  = 3'd0,
        ACT_DESTROY = 3'd1,
        ACT_QUERY   = 3'd2,
        ACT_FIND    = 3'd3,
        ACT_CLEAR   = 3'd4
    } action_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DEAD = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic              alive;
        logic [GEN_W-1:0]  gen;
        logic [UUID_W-1:0] hi;
        logic [UUID_W-1:0] lo;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_POP   = 6'b000100,
        S_GREAD = 6'b001000,
        S_CHECK = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

endpackage

[rtl/generational_handle_allocator_core.sv]
// Generational handle allocator: slot table of uuid-keyed handles.
//
// Input stream s_*: one word per request (create, destroy, query, find, clear).
// Output stream m_*: exactly one result word per request, in order.
// Each slot holds live bit, generation and uuid in one synchronous RAM; freed
// slot indices sit in a second RAM used as a LIFO stack.
// Per word: destroy and query read the slot and check its handle; clear and an
// unused action go straight to the result; find scans the used slots; create
// scans them too and, if its uuid is not found, pops a freed slot or appends
// a new one. Create and find walk the entry RAM one slot a cycle over its
// single read port.
// One request is in flight at a time; s_tready is high while the sequencer is
// idle, also while a result still waits in the output register.
// If m_tready is low the result holds in the output register and the next
// request stalls only once its own result is ready.
// Reset and clear zero the slot count, so no slot reads as live until it is
// allocated again; the auto uuid restarts at one.
`timescale 1ns / 1ps
module generational_handle_allocator_core
    import gha_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    // action[2:0], uuid_high[66:3], uuid_low[130:67], slot_index[138:131],
    // slot_generation[170:139], zero fill
    input  logic [IN_W-1:0]   s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // status[1:0], out_index[9:2], out_generation[41:10], out_uuid_high[105:42],
    // out_uuid_low[169:106], live_count[178:170], zero fill
    output logic [OUT_W-1:0]  m_tdata
);

    state_t              state_reg, state_next;
    logic [2:0]          act_reg, act_next;
    logic [UUID_W-1:0]   key_hi_reg, key_hi_next, key_lo_reg, key_lo_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [GEN_W-1:0]    gen_reg, gen_next;
    logic [UUID_W-1:0]   nxt_reg, nxt_next;
    logic [CNT_W-1:0]    scan_reg, scan_next;
    logic                pend_reg, pend_next;
    logic [IDX_W-1:0]    pidx_reg, pidx_next;
    logic                zhit_reg, zhit_next;
    logic [IDX_W-1:0]    zidx_reg, zidx_next;
    logic [IDX_W-1:0]    slot_reg, slot_next;
    logic [CNT_W-1:0]    free_top_reg, free_top_next;
    logic [CNT_W-1:0]    used_reg, used_next;
    logic [CNT_W-1:0]    live_reg, live_next;
    logic [UUID_W-1:0]   next_uuid_reg, next_uuid_next;
    logic [1:0]          res_st_reg, res_st_next;
    logic [IDX_W-1:0]    res_idx_reg, res_idx_next;
    entry_t              res_ent_reg, res_ent_next;
    logic                m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]    out_reg, out_next;

    logic                ent_we;
    logic [IDX_W-1:0]    ent_waddr, ent_raddr;
    entry_t              ent_wdata, ent_rdata;
    logic                fs_we;
    logic [IDX_W-1:0]    fs_waddr, fs_raddr, fs_wdata, fs_rdata;

    logic                key_match;
    logic [UUID_W-1:0]   s_hi, s_lo;
    logic                handle_ok;

    gha_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    gha_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS)) u_free_ram (
        .clk   (clk),
        .we    (fs_we),
        .waddr (fs_waddr),
        .wdata (fs_wdata),
        .raddr (fs_raddr),
        .rdata (fs_rdata)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_reg;

    assign s_hi = s_tdata[66:3];
    assign s_lo = s_tdata[130:67];

    assign key_match = ent_rdata.alive && (ent_rdata.hi == key_hi_reg)
                       && (ent_rdata.lo == key_lo_reg);
    assign handle_ok = (gen_reg != '0) && ({1'b0, idx_reg} < used_reg)
                       && ent_rdata.alive && (ent_rdata.gen == gen_reg);

    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        key_hi_next    = key_hi_reg;
        key_lo_next    = key_lo_reg;
        idx_next       = idx_reg;
        gen_next       = gen_reg;
        nxt_next       = nxt_reg;
        scan_next      = scan_reg;
        pend_next      = pend_reg;
        pidx_next      = pidx_reg;
        zhit_next      = zhit_reg;
        zidx_next      = zidx_reg;
        slot_next      = slot_reg;
        free_top_next  = free_top_reg;
        used_next      = used_reg;
        live_next      = live_reg;
        next_uuid_next = next_uuid_reg;
        res_st_next    = res_st_reg;
        res_idx_next   = res_idx_reg;
        res_ent_next   = res_ent_reg;
        m_valid_next   = m_valid_reg;
        out_next       = out_reg;
        ent_we         = 1'b0;
        ent_waddr      = slot_reg;
        ent_wdata      = '{alive: 1'b1, gen: '0, hi: key_hi_reg, lo: key_lo_reg};
        ent_raddr      = scan_reg[IDX_W-1:0];
        fs_we          = 1'b0;
        fs_waddr       = free_top_reg[IDX_W-1:0];
        fs_wdata       = idx_reg;
        fs_raddr       = free_top_reg[IDX_W-1:0] - 1'b1;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    act_next     = s_tdata[2:0];
                    key_hi_next  = s_hi;
                    key_lo_next  = s_lo;
                    idx_next     = s_tdata[138:131];
                    gen_next     = s_tdata[170:139];
                    nxt_next     = next_uuid_reg;
                    scan_next    = '0;
                    pend_next    = 1'b0;
                    zhit_next    = 1'b0;
                    res_st_next  = ST_OK;
                    res_idx_next = '0;
                    res_ent_next = '0;
                    ent_raddr    = s_tdata[138:131];
                    case (s_tdata[2:0])
                        ACT_CREATE:
                        begin
                            // substitute the auto uuid for an all-zero key
                            if (s_hi == '0 && s_lo == '0)
                            begin
                                key_lo_next = next_uuid_reg;
                                nxt_next    = next_uuid_reg + 1'b1;
                            end
                            state_next = S_SCAN;
                        end
                        ACT_FIND:
                        begin
                            state_next = S_SCAN;
                        end
                        ACT_DESTROY, ACT_QUERY:
                        begin
                            state_next = S_CHECK;
                        end
                        ACT_CLEAR:
                        begin
                            // slots at or above the slot count never read as live
                            free_top_next  = '0;
                            used_next      = '0;
                            live_next      = '0;
                            next_uuid_next = UUID_W'(1);
                            state_next     = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (pend_reg && key_match && ent_rdata.gen != '0)
                begin
                    res_idx_next = pidx_reg;
                    res_ent_next = ent_rdata;
                    if (act_reg == ACT_CREATE)
                    begin
                        next_uuid_next = nxt_reg;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    if (pend_reg && key_match && !zhit_reg)
                    begin
                        zhit_next = 1'b1;
                        zidx_next = pidx_reg;
                    end
                    if (scan_reg < used_reg)
                    begin
                        ent_raddr = scan_reg[IDX_W-1:0];
                        pidx_next = scan_reg[IDX_W-1:0];
                        scan_next = scan_reg + 1'b1;
                        pend_next = 1'b1;
                    end
                    else if (act_reg == ACT_FIND)
                    begin
                        if (zhit_reg || (pend_reg && key_match))
                        begin
                            res_idx_next = zhit_reg ? zidx_reg : pidx_reg;
                            res_ent_next = '{alive: 1'b1, gen: '0,
                                             hi: key_hi_reg, lo: key_lo_reg};
                        end
                        else
                        begin
                            res_st_next = ST_DEAD;
                        end
                        state_next = S_DONE;
                    end
                    else if (free_top_reg != '0)
                    begin
                        fs_raddr      = free_top_reg[IDX_W-1:0] - 1'b1;
                        free_top_next = free_top_reg - 1'b1;
                        state_next    = S_POP;
                    end
                    else if (used_reg < CNT_W'(SLOTS))
                    begin
                        ent_we          = 1'b1;
                        ent_waddr       = used_reg[IDX_W-1:0];
                        ent_wdata.gen   = GEN_W'(1);
                        used_next       = used_reg + 1'b1;
                        live_next       = live_reg + 1'b1;
                        res_idx_next    = used_reg[IDX_W-1:0];
                        res_ent_next    = '{alive: 1'b1, gen: GEN_W'(1),
                                            hi: key_hi_reg, lo: key_lo_reg};
                        next_uuid_next  = (key_hi_reg == '0 && key_lo_reg >= nxt_reg)
                                          ? key_lo_reg + 1'b1 : nxt_reg;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        res_st_next = ST_FULL;
                        state_next  = S_DONE;
                    end
                end
            end

            S_POP:
            begin
                ent_raddr  = fs_rdata;
                slot_next  = fs_rdata;
                state_next = S_GREAD;
            end

            S_GREAD:
            begin
                ent_we         = 1'b1;
                ent_waddr      = slot_reg;
                ent_wdata.gen  = ent_rdata.gen + 1'b1;
                live_next      = live_reg + 1'b1;
                res_idx_next   = slot_reg;
                res_ent_next   = '{alive: 1'b1, gen: ent_rdata.gen + 1'b1,
                                   hi: key_hi_reg, lo: key_lo_reg};
                next_uuid_next = (key_hi_reg == '0 && key_lo_reg >= nxt_reg)
                                 ? key_lo_reg + 1'b1 : nxt_reg;
                state_next     = S_DONE;
            end

            S_CHECK:
            begin
                if (handle_ok)
                begin
                    res_idx_next = idx_reg;
                    res_ent_next = ent_rdata;
                    if (act_reg == ACT_DESTROY)
                    begin
                        // write the entry back with its live bit dropped
                        ent_we          = 1'b1;
                        ent_waddr       = idx_reg;
                        ent_wdata       = ent_rdata;
                        ent_wdata.alive = 1'b0;
                        if (free_top_reg < CNT_W'(SLOTS))
                        begin
                            fs_we         = 1'b1;
                            fs_waddr      = free_top_reg[IDX_W-1:0];
                            fs_wdata      = idx_reg;
                            free_top_next = free_top_reg + 1'b1;
                        end
                        if (live_reg != '0)
                        begin
                            live_next = live_reg - 1'b1;
                        end
                    end
                end
                else
                begin
                    res_st_next = ST_DEAD;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // load the output register once the previous word has gone
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    out_next     = {5'b0, live_reg, res_ent_reg.lo, res_ent_reg.hi,
                                    res_ent_reg.gen, res_idx_reg, res_st_reg};
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scan_reg      <= '0;
            pend_reg      <= 1'b0;
            zhit_reg      <= 1'b0;
            free_top_reg  <= '0;
            used_reg      <= '0;
            live_reg      <= '0;
            next_uuid_reg <= UUID_W'(1);
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            pend_reg      <= pend_next;
            zhit_reg      <= zhit_next;
            free_top_reg  <= free_top_next;
            used_reg      <= used_next;
            live_reg      <= live_next;
            next_uuid_reg <= next_uuid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg     <= act_next;
        key_hi_reg  <= key_hi_next;
        key_lo_reg  <= key_lo_next;
        idx_reg     <= idx_next;
        gen_reg     <= gen_next;
        nxt_reg     <= nxt_next;
        pidx_reg    <= pidx_next;
        zidx_reg    <= zidx_next;
        slot_reg    <= slot_next;
        res_st_reg  <= res_st_next;
        res_idx_reg <= res_idx_next;
        res_ent_reg <= res_ent_next;
        out_reg     <= out_next;
    end

endmodule

[rtl/gha_ram.sv]
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module gha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/gha_checker.sv]
// Port-level assertions for the generational handle allocator.
`timescale 1ns / 1ps
module gha_checker
    import gha_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    // a stalled result word stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[1:0] != 2'd3)
        else $error("undefined status code");

    // failures carry no handle
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] != ST_OK |-> m_tdata[169:2] == '0)
        else $error("failed result carries a handle");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[178] && m_tdata[177:170] != '0))
        else $error("live count above table size");

endmodule

bind generational_handle_allocator_core gha_checker u_gha_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[tb/testbench.sv]
// Self-checking testbench of the generational handle allocator core.
`timescale 1ns / 1ps
module testbench;
    import gha_pkg::*;

    typedef struct {
        logic [2:0]        action;
        logic [UUID_W-1:0] hi;
        logic [UUID_W-1:0] lo;
        logic [IDX_W-1:0]  idx;
        logic [GEN_W-1:0]  gen;
        bit                drain;
    } request_t;

    typedef struct {
        logic [1:0]        status;
        logic [IDX_W-1:0]  idx;
        logic [GEN_W-1:0]  gen;
        logic [UUID_W-1:0] hi;
        logic [UUID_W-1:0] lo;
        logic [CNT_W-1:0]  live;
    } handle_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;

    generational_handle_allocator_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 clk = ~clk;

    // Shadow of the slot table
    bit                tbl_alive [SLOTS];
    logic [GEN_W-1:0]  tbl_gen   [SLOTS];
    logic [UUID_W-1:0] tbl_hi    [SLOTS];
    logic [UUID_W-1:0] tbl_lo    [SLOTS];
    logic [IDX_W-1:0]  tbl_free  [SLOTS];
    int                tbl_free_top = 0;
    int                tbl_used = 0;
    int                tbl_live = 0;
    logic [UUID_W-1:0] tbl_next_uuid = 64'd1;

    request_t          pending_requests [$];
    handle_result_t    expected_results [$];
    int                queued_cnt = 0;
    int                sent_cnt = 0;
    int                recv_cnt = 0;
    int                mismatches = 0;
    bit                stimulus_done = 0;

    function automatic handle_result_t slot_result(int s);
        handle_result_t o;
        o.status = ST_OK;
        o.idx = s[IDX_W-1:0];
        o.gen = tbl_gen[s];
        o.hi = tbl_hi[s];
        o.lo = tbl_lo[s];
        o.live = tbl_live[CNT_W-1:0];
        return o;
    endfunction

    function automatic handle_result_t empty_result(logic [1:0] st);
        handle_result_t o;
        o.status = st;
        o.idx = '0;
        o.gen = '0;
        o.hi = '0;
        o.lo = '0;
        o.live = tbl_live[CNT_W-1:0];
        return o;
    endfunction

    function automatic bit handle_is_live(logic [IDX_W-1:0] idx, logic [GEN_W-1:0] gen);
        return gen != 0 && int'(idx) < tbl_used && tbl_alive[idx] && tbl_gen[idx] == gen;
    endfunction

    function automatic int find_uuid(logic [UUID_W-1:0] hi, logic [UUID_W-1:0] lo, bit nz);
        for (int i = 0; i < tbl_used; i++)
            if (tbl_alive[i] && tbl_hi[i] == hi && tbl_lo[i] == lo && (!nz || tbl_gen[i] != 0))
                return i;
        return SLOTS;
    endfunction

    function automatic handle_result_t allocate(request_t r);
        logic [UUID_W-1:0] hi;
        logic [UUID_W-1:0] lo;
        logic [UUID_W-1:0] nxt;
        int s;
        hi = r.hi;
        lo = r.lo;
        nxt = tbl_next_uuid;
        if (hi == 0 && lo == 0) begin
            lo = nxt;
            nxt = nxt + 1;
        end
        s = find_uuid(hi, lo, 1);
        if (s < SLOTS) begin
            tbl_next_uuid = nxt;
            return slot_result(s);
        end
        if (tbl_free_top > 0) begin
            tbl_free_top--;
            s = tbl_free[tbl_free_top];
            tbl_gen[s] = tbl_gen[s] + 1;
        end else if (tbl_used < SLOTS) begin
            s = tbl_used;
            tbl_used++;
            tbl_gen[s] = 1;
        end else begin
            return empty_result(ST_FULL);
        end
        tbl_alive[s] = 1;
        tbl_hi[s] = hi;
        tbl_lo[s] = lo;
        tbl_live++;
        if (hi == 0 && lo >= nxt)
            nxt = lo + 1;
        tbl_next_uuid = nxt;
        return slot_result(s);
    endfunction

    function automatic handle_result_t predict_handle(request_t r);
        int s;
        case (r.action)
            ACT_CREATE: return allocate(r);
            ACT_DESTROY:
            begin
                if (!handle_is_live(r.idx, r.gen))
                    return empty_result(ST_DEAD);
                tbl_alive[r.idx] = 0;
                if (tbl_free_top < SLOTS) begin
                    tbl_free[tbl_free_top] = r.idx;
                    tbl_free_top++;
                end
                if (tbl_live > 0)
                    tbl_live--;
                return slot_result(r.idx);
            end
            ACT_QUERY:
            begin
                if (handle_is_live(r.idx, r.gen))
                    return slot_result(r.idx);
                return empty_result(ST_DEAD);
            end
            ACT_FIND:
            begin
                s = find_uuid(r.hi, r.lo, 1);
                if (s >= SLOTS)
                    s = find_uuid(r.hi, r.lo, 0);
                if (s < SLOTS)
                    return slot_result(s);
                return empty_result(ST_DEAD);
            end
            ACT_CLEAR:
            begin
                for (int i = 0; i < SLOTS; i++)
                    tbl_alive[i] = 0;
                tbl_free_top = 0;
                tbl_used = 0;
                tbl_live = 0;
                tbl_next_uuid = 64'd1;
                return empty_result(ST_OK);
            end
            default: return empty_result(ST_OK);
        endcase
    endfunction

    // Requests are accepted in queue order, so predict at enqueue time
    task automatic enqueue(logic [2:0] act, logic [UUID_W-1:0] hi, logic [UUID_W-1:0] lo,
                           logic [IDX_W-1:0] idx, logic [GEN_W-1:0] gen, bit drain = 0);
        request_t r;
        r.action = act;
        r.hi = hi;
        r.lo = lo;
        r.idx = idx;
        r.gen = gen;
        r.drain = drain;
        pending_requests.insert(pending_requests.size(), r);
        expected_results.insert(expected_results.size(), predict_handle(r));
        queued_cnt++;
    endtask

    function automatic int pick_live_slot();
        int start;
        int s;
        if (tbl_used == 0)
            return SLOTS;
        start = $urandom_range(0, tbl_used - 1);
        for (int k = 0; k < tbl_used; k++) begin
            s = (start + k) % tbl_used;
            if (tbl_alive[s])
                return s;
        end
        return SLOTS;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic random_item();
        int sel;
        int s;
        int sub;
        logic [63:0] hi;
        logic [63:0] lo;
        sel = $urandom_range(0, 99);
        s = pick_live_slot();
        sub = $urandom_range(0, 7);
        if (tbl_used > 40 && $urandom_range(0, 3) == 0)
            enqueue(ACT_CLEAR, rand64(), rand64(), IDX_W'($urandom), GEN_W'($urandom));
        else if (sel < 35) begin
            hi = rand64();
            lo = rand64();
            if (sub < 2) begin
                hi = 0;
                lo = 0;
            end else if (sub < 4 && s < SLOTS) begin
                hi = tbl_hi[s];
                lo = tbl_lo[s];
            end else if (sub == 4) begin
                hi = 0;
                lo = $urandom_range(0, 40) + tbl_next_uuid;
            end
            enqueue(ACT_CREATE, hi, lo, IDX_W'($urandom), GEN_W'($urandom));
        end else if (sel < 80) begin
            // destroy or query: mostly a live handle, some stale or random
            if (sub < 5 && s < SLOTS)
                enqueue(sel < 60 ? ACT_DESTROY : ACT_QUERY, rand64(), rand64(),
                        IDX_W'(s), tbl_gen[s]);
            else if (sub < 7 && tbl_used > 0) begin
                s = $urandom_range(0, tbl_used - 1);
                enqueue(sel < 60 ? ACT_DESTROY : ACT_QUERY, rand64(), rand64(),
                        IDX_W'(s), tbl_gen[s] + $urandom_range(0, 2) - 1);
            end else
                enqueue(sel < 60 ? ACT_DESTROY : ACT_QUERY, rand64(), rand64(),
                        IDX_W'($urandom), GEN_W'($urandom));
        end else if (sel < 95) begin
            if (sub < 5 && tbl_used > 0) begin
                s = $urandom_range(0, tbl_used - 1);
                enqueue(ACT_FIND, tbl_hi[s], tbl_lo[s], IDX_W'($urandom), GEN_W'($urandom));
            end else
                enqueue(ACT_FIND, rand64(), rand64(), IDX_W'($urandom), GEN_W'($urandom));
        end else if (sel < 97)
            enqueue(ACT_CLEAR, rand64(), rand64(), IDX_W'($urandom), GEN_W'($urandom));
        else
            enqueue(3'($urandom_range(5, 7)), rand64(), rand64(),
                    IDX_W'($urandom), GEN_W'($urandom));
    endtask

    initial
    begin
        logic [63:0] ones;
        ones = '1;
        // directed part
        enqueue(ACT_CREATE, 0, 0, 0, 0);
        enqueue(ACT_CREATE, 0, 0, 8'hFF, ones[31:0]);
        enqueue(ACT_CREATE, 0, 64'd10, 0, 0);
        enqueue(ACT_CREATE, 0, 0, 0, 0);
        enqueue(ACT_CREATE, 0, 64'd10, 0, 0);
        enqueue(ACT_CREATE, ones, ones, 0, 0);
        enqueue(ACT_CREATE, 0, ones, 0, 0);
        enqueue(ACT_FIND, ones, ones, 0, 0);
        enqueue(ACT_FIND, 64'd5, 64'd5, 0, 0);
        enqueue(ACT_QUERY, 0, 0, 8'd1, 32'd1);
        enqueue(ACT_QUERY, 0, 0, 8'd1, 32'd0);
        enqueue(ACT_QUERY, 0, 0, 8'hFF, 32'd1);
        enqueue(ACT_DESTROY, 0, 0, 8'd2, 32'd1);
        enqueue(ACT_DESTROY, 0, 0, 8'd2, 32'd1);
        enqueue(ACT_FIND, 0, 64'd10, 0, 0);
        enqueue(ACT_CREATE, 64'd7, 64'd7, 0, 0);
        enqueue(ACT_QUERY, 0, 0, 8'd2, 32'd1);
        enqueue(ACT_QUERY, 0, 0, 8'd2, 32'd2);
        enqueue(3'd5, ones, ones, 8'hFF, ones[31:0]);
        enqueue(3'd6, 0, 0, 0, 0);
        enqueue(3'd7, 0, 0, 0, 0);
        enqueue(ACT_CLEAR, 0, 0, 0, 0);
        enqueue(ACT_QUERY, 0, 0, 8'd0, 32'd1);
        enqueue(ACT_CREATE, 0, 0, 0, 0, 1);
        for (int n = 0; n < 1500; n++) begin
            if (n == 700) begin
                // fill the table to the brim, then probe it while full
                enqueue(ACT_CLEAR, 0, 0, 0, 0);
                for (int k = 0; k < SLOTS; k++)
                    enqueue(ACT_CREATE, rand64(), rand64(), 0, 0);
                enqueue(ACT_CREATE, 0, 0, 0, 0);
                enqueue(ACT_CREATE, rand64(), rand64(), 0, 0);
                enqueue(ACT_CREATE, tbl_hi[SLOTS-1], tbl_lo[SLOTS-1], 0, 0);
                enqueue(ACT_FIND, tbl_hi[SLOTS-1], tbl_lo[SLOTS-1], 0, 0);
                enqueue(ACT_QUERY, 0, 0, 8'hFF, 32'd1);
                enqueue(ACT_DESTROY, 0, 0, 8'hFF, 32'd1);
                enqueue(ACT_CREATE, 0, 0, 0, 0);
                enqueue(ACT_CLEAR, 0, 0, 0, 0, 1);
            end
            random_item();
        end
        stimulus_done = 1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_requests.size() == 0 && recv_cnt == queued_cnt);
        repeat (300) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("generational_handle_allocator_core verification clean");
        else
            $display("generational_handle_allocator_core verification failed");
        $finish;
    end

    initial
    begin
        #40ms;
        $display("generational_handle_allocator_core verification failed");
        $finish;
    end

    // Driver: bursts of words with random gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        request_t r;
        bit fire;
        int sent;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            fire = s_tvalid && s_tready;
            sent = sent_cnt + fire;
            if (fire)
                sent_cnt <= sent;
            if (!s_tvalid || fire) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_requests.size() > 0 &&
                             (!pending_requests[0].drain || sent == recv_cnt)) begin
                    r = pending_requests.pop_front();
                    s_tdata <= {5'b0, r.gen, r.idx, r.lo, r.hi, r.action};
                    s_tvalid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 30);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
                    end else
                        burst_left <= burst_left - 1;
                end else
                    s_tvalid <= 1'b0;
            end
        end
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch on result %0d: %s got %h want %h", recv_cnt, what, got, want);
        mismatches++;
    endtask

    // Monitor: receiver stall pattern changes mode at random
    int stall_mode = 0;
    int mode_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        handle_result_t e;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                recv_cnt <= recv_cnt + 1;
                if (expected_results.size() == 0)
                    report_mismatch("unexpected word", m_tdata[63:0], 0);
                else begin
                    e = expected_results.pop_front();
                    if (m_tdata[1:0] != e.status)
                        report_mismatch("status", m_tdata[1:0], e.status);
                    if (m_tdata[9:2] != e.idx)
                        report_mismatch("out_index", m_tdata[9:2], e.idx);
                    if (m_tdata[41:10] != e.gen)
                        report_mismatch("out_generation", m_tdata[41:10], e.gen);
                    if (m_tdata[105:42] != e.hi)
                        report_mismatch("out_uuid_high", m_tdata[105:42], e.hi);
                    if (m_tdata[169:106] != e.lo)
                        report_mismatch("out_uuid_low", m_tdata[169:106], e.lo);
                    if (m_tdata[178:170] != e.live)
                        report_mismatch("live_count", m_tdata[178:170], e.live);
                end
            end
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(0, 3);
                mode_left <= $urandom_range(50, 400);
            end else
                mode_left <= mode_left - 1;
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= $urandom_range(0, 1);
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ((mode_left % 16) < 10);
            endcase
        end
    end

endmodule

[generational_handle_allocator_core.f]
rtl/gha_pkg.sv
rtl/gha_ram.sv
rtl/generational_handle_allocator_core.sv
rtl/gha_checker.sv
tb/testbench.sv
